>>> rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, register indexes and compensation constants for the
// barometric pressure / temperature compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

    // beat field widths
    localparam int UT_W   = 16;
    localparam int UP_W   = 19;
    localparam int OSS_W  = 2;
    localparam int TEMP_W = 16;
    localparam int PRES_W = 18;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_AC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_PAIR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_M_TRIPLE  = 2'd3;

    // compensation constants
    localparam logic signed [12:0] C_B6_OFFSET = 13'sd4000;
    localparam logic [31:0]        C_B4_BIAS   = 32'd32768;
    localparam logic [15:0]        C_B7_SCALE  = 16'd50000;
    localparam logic signed [12:0] C_P_SQ_MUL  = 13'sd3038;
    localparam logic signed [14:0] C_P_LIN_MUL = -15'sd7357;
    localparam logic signed [17:0] C_P_OFFSET  = 18'sd3791;

    // pressure saturation limit
    localparam logic [PRES_W-1:0] C_PRES_MAX = 18'd262143;

endpackage

>>> rtl/bpc_in_if.sv
// ----------------------------------------------------------------------------
// bpc_in_if
// Sample channel: raw temperature, raw pressure and oversampling setting.
// ----------------------------------------------------------------------------
interface bpc_in_if;
    logic                        valid;
    logic                        ready;
    logic [bpc_pkg::UT_W-1:0]    raw_temperature;
    logic [bpc_pkg::UP_W-1:0]    uncomp_pressure;
    logic [bpc_pkg::OSS_W-1:0]   oversampling;

    modport source (output valid, output raw_temperature, output uncomp_pressure,
                    output oversampling, input ready);
    modport sink   (input valid, input raw_temperature, input uncomp_pressure,
                    input oversampling, output ready);
endinterface

>>> rtl/bpc_out_if.sv
// ----------------------------------------------------------------------------
// bpc_out_if
// Result channel: compensated temperature, pressure and error flag.
// ----------------------------------------------------------------------------
interface bpc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [bpc_pkg::TEMP_W-1:0] temperature_tenths;
    logic [bpc_pkg::PRES_W-1:0]        pressure_pa;
    logic                              math_error;

    modport source (output valid, output temperature_tenths, output pressure_pa,
                    output math_error, input ready);
    modport sink   (input valid, input temperature_tenths, input pressure_pa,
                    input math_error, output ready);
endinterface

>>> rtl/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// sideband word and a valid bit carried alongside each operand pair.
// ----------------------------------------------------------------------------
module bpc_div #(
    parameter int NW = 32,
    parameter int DW = 17,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);
    localparam int AW = DW + NW;

    // accumulator holds remainder on top, dividend / quotient bits below
    wire [AW-1:0] w_acc  [0:NW];
    wire [DW-1:0] w_den  [0:NW];
    wire [SW-1:0] w_side [0:NW];
    wire          w_vld  [0:NW];

    assign w_acc[0]  = {{DW{1'b0}}, i_num};
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;
    assign w_vld[0]  = i_valid;

    for (genvar k = 0; k < NW; k++) begin : g_step
        logic [AW:0]   w_sh;
        logic [DW:0]   w_top;
        logic [DW:0]   w_dif;
        logic [AW-1:0] n_acc;
        logic [AW-1:0] r_acc;
        logic [DW-1:0] r_den;
        logic [SW-1:0] r_side;
        logic          r_vld;

        // shift in one dividend bit and try to subtract
        always_comb begin
            w_sh  = {w_acc[k], 1'b0};
            w_top = w_sh[AW:NW];
            w_dif = w_top - {1'b0, w_den[k]};
            if (!w_dif[DW]) begin
                n_acc = {w_dif[DW-1:0], w_sh[NW-1:1], 1'b1};
            end else begin
                n_acc = w_sh[AW-1:0];
            end
        end

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[k];
            end
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc  <= n_acc;
                r_den  <= w_den[k];
                r_side <= w_side[k];
            end
        end

        assign w_acc[k+1]  = r_acc;
        assign w_den[k+1]  = r_den;
        assign w_side[k+1] = r_side;
        assign w_vld[k+1]  = r_vld;
    end

    assign o_valid = w_vld[NW];
    assign o_quo   = w_acc[NW][NW-1:0];
    assign o_side  = w_side[NW];
endmodule

>>> rtl/baro_pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Integer temperature and pressure compensation from raw sensor words.
// ----------------------------------------------------------------------------
// most of the pipeline lies in the two bit-per-stage dividers (27 stages for
//   the temperature term, 32 for the pressure term); throughput: one sample
//   per cycle while the result is not stalled, all stages pipelined
// a stalled result holds the whole pipeline in place; nothing is dropped
// reset (synchronous, active low) clears all valid bits and coefficients
module baro_pressure_temp_compensation (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bpc_in_if.sink                         i_smp,
    bpc_out_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int D1_NW = 27;
    localparam int D1_DW = 18;
    localparam int D1_SW = 40;
    localparam int D2_NW = 32;
    localparam int D2_DW = 17;
    localparam int D2_SW = 18;

    // coefficient registers
    logic [47:0] r_ac_first;
    logic [47:0] r_ac_second;
    logic [31:0] r_b_pair;
    logic [47:0] r_m_triple;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac_first  <= '0;
            r_ac_second <= '0;
            r_b_pair    <= '0;
            r_m_triple  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpc_pkg::CFG_AC_FIRST:  r_ac_first  <= i_cfg_data[47:0];
                bpc_pkg::CFG_AC_SECOND: r_ac_second <= i_cfg_data[47:0];
                bpc_pkg::CFG_B_PAIR:    r_b_pair    <= i_cfg_data[31:0];
                bpc_pkg::CFG_M_TRIPLE:  r_m_triple  <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // coefficient fields
    logic signed [15:0] w_ac1, w_ac2, w_ac3, w_b1, w_b2, w_mc, w_md;
    logic [15:0]        w_ac4, w_ac5, w_ac6;
    logic [15:0]        w_mb_unused;

    assign w_ac1 = $signed(r_ac_first[47:32]);
    assign w_ac2 = $signed(r_ac_first[31:16]);
    assign w_ac3 = $signed(r_ac_first[15:0]);
    assign w_ac4 = r_ac_second[47:32];
    assign w_ac5 = r_ac_second[31:16];
    assign w_ac6 = r_ac_second[15:0];
    assign w_b1  = $signed(r_b_pair[31:16]);
    assign w_b2  = $signed(r_b_pair[15:0]);
    assign w_mb_unused = r_m_triple[47:32];
    assign w_mc  = $signed(r_m_triple[31:16]);
    assign w_md  = $signed(r_m_triple[15:0]);

    // global advance: the output register is free or being drained
    logic w_adv;
    logic r_out_vld;
    assign w_adv       = !r_out_vld || o_res.ready;
    assign i_smp.ready = w_adv;

    // ---------------- stage 1: (ut - ac6) * ac5
    logic signed [16:0] w_s1_a, w_s1_b;
    logic signed [33:0] w_s1_p;
    logic               r1_vld;
    logic [31:0]        r1_p;
    logic [18:0]        r1_up;
    logic [1:0]         r1_oss;

    assign w_s1_a = $signed({1'b0, i_smp.raw_temperature}) - $signed({1'b0, w_ac6});
    assign w_s1_b = $signed({1'b0, w_ac5});
    assign w_s1_p = w_s1_a * w_s1_b;

    // ---------------- stage 2: x1, denominator, divider operands
    logic signed [16:0] w_s2_x1;
    logic signed [17:0] w_s2_den;
    logic signed [26:0] w_s2_num;
    logic               r2_vld;
    logic [26:0]        r2_nmag;
    logic [17:0]        r2_dmag;
    logic               r2_qneg;
    logic               r2_err;
    logic signed [16:0] r2_x1;
    logic [18:0]        r2_up;
    logic [1:0]         r2_oss;

    assign w_s2_x1  = $signed(r1_p[31:15]);
    assign w_s2_den = 18'(w_s2_x1) + 18'(w_md);
    assign w_s2_num = {w_mc, 11'b0};

    // ---------------- divider 1: mc * 2048 / (x1 + md)
    logic [D1_SW-1:0] w_d1_side_in, w_d1_side_out;
    logic             w_d1_vld;
    logic [D1_NW-1:0] w_d1_quo;

    assign w_d1_side_in = {r2_x1, r2_qneg, r2_err, r2_up, r2_oss};

    bpc_div #(.NW(D1_NW), .DW(D1_DW), .SW(D1_SW)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r2_vld),
        .i_num   (r2_nmag),
        .i_den   (r2_dmag),
        .i_side  (w_d1_side_in),
        .o_valid (w_d1_vld),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_side_out)
    );

    // ---------------- stage 4: b5, temperature, b6
    logic signed [16:0] w_s4_x1;
    logic               w_s4_qneg;
    logic               w_s4_err;
    logic [18:0]        w_s4_up;
    logic [1:0]         w_s4_oss;
    logic signed [27:0] w_s4_x2, w_s4_b5, w_s4_b6, w_s4_t8;
    logic signed [23:0] w_s4_t;
    logic signed [15:0] w_s4_tsat;
    logic               r4_vld;
    logic signed [27:0] r4_b6;
    logic signed [15:0] r4_t;
    logic               r4_err;
    logic [18:0]        r4_up;
    logic [1:0]         r4_oss;

    assign {w_s4_x1, w_s4_qneg, w_s4_err, w_s4_up, w_s4_oss} = w_d1_side_out;

    always_comb begin
        if (w_s4_qneg) begin
            w_s4_x2 = -$signed({1'b0, w_d1_quo});
        end else begin
            w_s4_x2 = $signed({1'b0, w_d1_quo});
        end
        w_s4_b5 = 28'(w_s4_x1) + w_s4_x2;
        w_s4_b6 = w_s4_b5 - 28'(bpc_pkg::C_B6_OFFSET);
        w_s4_t8 = w_s4_b5 + 28'sd8;
        w_s4_t  = w_s4_t8[27:4];
        if (w_s4_t > 24'sd32767) begin
            w_s4_tsat = 16'sd32767;
        end else if (w_s4_t < -24'sd32768) begin
            w_s4_tsat = -16'sd32768;
        end else begin
            w_s4_tsat = w_s4_t[15:0];
        end
    end

    // ---------------- stage 5: b6 products
    logic signed [55:0] w_s5_sq;
    logic signed [43:0] w_s5_a2, w_s5_a3;
    logic               r5_vld;
    logic [31:0]        r5_sq, r5_a2, r5_a3;
    logic signed [15:0] r5_t;
    logic               r5_err;
    logic [18:0]        r5_up;
    logic [1:0]         r5_oss;

    assign w_s5_sq = r4_b6 * r4_b6;
    assign w_s5_a2 = w_ac2 * r4_b6;
    assign w_s5_a3 = w_ac3 * r4_b6;

    // ---------------- stage 6: b2 * sq, b1 * sq
    logic signed [19:0] w_s6_sq;
    logic signed [35:0] w_s6_b2sq, w_s6_b1sq;
    logic               r6_vld;
    logic [31:0]        r6_b2sq, r6_b1sq;
    logic signed [20:0] r6_x2a;
    logic signed [18:0] r6_x1c;
    logic signed [15:0] r6_t;
    logic               r6_err;
    logic [18:0]        r6_up;
    logic [1:0]         r6_oss;

    assign w_s6_sq   = $signed(r5_sq[31:12]);
    assign w_s6_b2sq = w_b2 * w_s6_sq;
    assign w_s6_b1sq = w_b1 * w_s6_sq;

    // ---------------- stage 7: b3 and x3 for b4
    logic signed [20:0] w_s7_x1;
    logic signed [21:0] w_s7_x3;
    logic signed [22:0] w_s7_v;
    logic signed [26:0] w_s7_vs, w_s7_v2, w_s7_v3;
    logic signed [24:0] w_s7_b3;
    logic signed [19:0] w_s7_s;
    logic               r7_vld;
    logic signed [24:0] r7_b3;
    logic signed [17:0] r7_x3c;
    logic signed [15:0] r7_t;
    logic               r7_err;
    logic [18:0]        r7_up;
    logic [1:0]         r7_oss;

    always_comb begin
        w_s7_x1 = $signed(r6_b2sq[31:11]);
        w_s7_x3 = 22'(w_s7_x1) + 22'(r6_x2a);
        w_s7_v  = 23'($signed({w_ac1, 2'b00})) + 23'(w_s7_x3);
        w_s7_vs = 27'(w_s7_v) <<< r6_oss;
        w_s7_v2 = w_s7_vs + 27'sd2;
        // divide by four, truncating toward zero
        if (w_s7_v2 < 0) begin
            w_s7_v3 = w_s7_v2 + 27'sd3;
        end else begin
            w_s7_v3 = w_s7_v2;
        end
        w_s7_b3 = w_s7_v3[26:2];
        w_s7_s  = 20'(r6_x1c) + 20'($signed(r6_b1sq[31:16])) + 20'sd2;
    end

    // ---------------- stage 8: b4 and up - b3
    logic [31:0] w_s8_x3b;
    logic [47:0] w_s8_b4f;
    logic [31:0] w_s8_diff;
    logic        r8_vld;
    logic [16:0] r8_b4;
    logic [31:0] r8_diff;
    logic signed [15:0] r8_t;
    logic        r8_err;
    logic [1:0]  r8_oss;

    assign w_s8_x3b  = 32'($signed(r7_x3c)) + bpc_pkg::C_B4_BIAS;
    assign w_s8_b4f  = 48'(w_ac4) * 48'(w_s8_x3b);
    assign w_s8_diff = 32'(r7_up) - 32'(r7_b3);

    // ---------------- stage 9: b7
    logic [15:0] w_s9_scale;
    logic [47:0] w_s9_b7f;
    logic        r9_vld;
    logic [31:0] r9_b7;
    logic [16:0] r9_b4;
    logic signed [15:0] r9_t;
    logic        r9_err;

    assign w_s9_scale = bpc_pkg::C_B7_SCALE >> r8_oss;
    assign w_s9_b7f   = 48'(r8_diff) * 48'(w_s9_scale);

    // ---------------- divider 2: b7 / b4
    logic [D2_NW-1:0] w_d2_num;
    logic [D2_SW-1:0] w_d2_side_in, w_d2_side_out;
    logic             w_d2_vld;
    logic [D2_NW-1:0] w_d2_quo;

    assign w_d2_num     = r9_b7[31] ? r9_b7 : {r9_b7[30:0], 1'b0};
    assign w_d2_side_in = {r9_b7[31], r9_t, r9_err};

    bpc_div #(.NW(D2_NW), .DW(D2_DW), .SW(D2_SW)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r9_vld),
        .i_num   (w_d2_num),
        .i_den   (r9_b4),
        .i_side  (w_d2_side_in),
        .o_valid (w_d2_vld),
        .o_quo   (w_d2_quo),
        .o_side  (w_d2_side_out)
    );

    // ---------------- stage 10: raw pressure and correction products
    logic               w_s10_hi;
    logic signed [15:0] w_s10_t;
    logic               w_s10_err;
    logic signed [31:0] w_s10_p;
    logic signed [23:0] w_s10_x1;
    logic signed [47:0] w_s10_x1sq;
    logic signed [46:0] w_s10_lin;
    logic               r10_vld;
    logic signed [31:0] r10_p;
    logic [31:0]        r10_x1sq, r10_lin;
    logic signed [15:0] r10_t;
    logic               r10_err;

    assign {w_s10_hi, w_s10_t, w_s10_err} = w_d2_side_out;
    assign w_s10_p    = w_s10_hi ? $signed({w_d2_quo[30:0], 1'b0}) : $signed(w_d2_quo);
    assign w_s10_x1   = w_s10_p[31:8];
    assign w_s10_x1sq = w_s10_x1 * w_s10_x1;
    assign w_s10_lin  = w_s10_p * bpc_pkg::C_P_LIN_MUL;

    // ---------------- stage 11: square term scaling
    logic signed [44:0] w_s11_m;
    logic               r11_vld;
    logic signed [31:0] r11_p;
    logic signed [15:0] r11_x1, r11_x2;
    logic signed [15:0] r11_t;
    logic               r11_err;

    assign w_s11_m = $signed(r10_x1sq) * bpc_pkg::C_P_SQ_MUL;

    // ---------------- stage 12: final pressure, saturation, output register
    logic signed [17:0] w_s12_s;
    logic signed [32:0] w_s12_sum;
    logic signed [31:0] w_s12_p;
    logic [17:0]        w_s12_psat;
    logic signed [15:0] r_out_t;
    logic [17:0]        r_out_p;
    logic               r_out_err;

    always_comb begin
        w_s12_s   = 18'(r11_x1) + 18'(r11_x2) + bpc_pkg::C_P_OFFSET;
        w_s12_sum = 33'(r11_p) + 33'($signed(w_s12_s[17:4]));
        w_s12_p   = w_s12_sum[31:0];
        if (w_s12_p < 0) begin
            w_s12_psat = '0;
        end else if (w_s12_p > 32'sd262143) begin
            w_s12_psat = bpc_pkg::C_PRES_MAX;
        end else begin
            w_s12_psat = w_s12_p[17:0];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r9_vld    <= 1'b0;
            r10_vld   <= 1'b0;
            r11_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld    <= i_smp.valid;
            r2_vld    <= r1_vld;
            r4_vld    <= w_d1_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            r8_vld    <= r7_vld;
            r9_vld    <= r8_vld;
            r10_vld   <= w_d2_vld;
            r11_vld   <= r10_vld;
            r_out_vld <= r11_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_p    <= w_s1_p[31:0];
            r1_up   <= i_smp.uncomp_pressure;
            r1_oss  <= i_smp.oversampling;

            r2_nmag <= w_s2_num[26] ? 27'(-w_s2_num) : 27'(w_s2_num);
            r2_dmag <= w_s2_den[17] ? 18'(-w_s2_den) : 18'(w_s2_den);
            r2_qneg <= w_s2_num[26] ^ w_s2_den[17];
            r2_err  <= (w_s2_den == 18'sd0);
            r2_x1   <= w_s2_x1;
            r2_up   <= r1_up;
            r2_oss  <= r1_oss;

            r4_b6   <= w_s4_b6;
            r4_t    <= w_s4_tsat;
            r4_err  <= w_s4_err;
            r4_up   <= w_s4_up;
            r4_oss  <= w_s4_oss;

            r5_sq   <= w_s5_sq[31:0];
            r5_a2   <= w_s5_a2[31:0];
            r5_a3   <= w_s5_a3[31:0];
            r5_t    <= r4_t;
            r5_err  <= r4_err;
            r5_up   <= r4_up;
            r5_oss  <= r4_oss;

            r6_b2sq <= w_s6_b2sq[31:0];
            r6_b1sq <= w_s6_b1sq[31:0];
            r6_x2a  <= $signed(r5_a2[31:11]);
            r6_x1c  <= $signed(r5_a3[31:13]);
            r6_t    <= r5_t;
            r6_err  <= r5_err;
            r6_up   <= r5_up;
            r6_oss  <= r5_oss;

            r7_b3   <= w_s7_b3;
            r7_x3c  <= w_s7_s[19:2];
            r7_t    <= r6_t;
            r7_err  <= r6_err;
            r7_up   <= r6_up;
            r7_oss  <= r6_oss;

            r8_b4   <= w_s8_b4f[31:15];
            r8_diff <= w_s8_diff;
            r8_t    <= r7_t;
            r8_err  <= r7_err;
            r8_oss  <= r7_oss;

            r9_b7   <= w_s9_b7f[31:0];
            r9_b4   <= r8_b4;
            r9_t    <= r8_t;
            r9_err  <= r8_err || (r8_b4 == '0);

            r10_p    <= w_s10_p;
            r10_x1sq <= w_s10_x1sq[31:0];
            r10_lin  <= w_s10_lin[31:0];
            r10_t    <= w_s10_t;
            r10_err  <= w_s10_err;

            r11_p   <= r10_p;
            r11_x1  <= w_s11_m[31:16];
            r11_x2  <= $signed(r10_lin[31:16]);
            r11_t   <= r10_t;
            r11_err <= r10_err;

            r_out_t   <= r11_err ? 16'sd0 : r11_t;
            r_out_p   <= r11_err ? '0 : w_s12_psat;
            r_out_err <= r11_err;
        end
    end

    // result beat
    assign o_res.valid              = r_out_vld;
    assign o_res.temperature_tenths = r_out_t;
    assign o_res.pressure_pa        = r_out_p;
    assign o_res.math_error         = r_out_err;
endmodule

>>> rtl/bpc_chk.sv
// ----------------------------------------------------------------------------
// bpc_chk
// Port-level checks for the compensation pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module bpc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_temp,
    input logic [17:0] i_out_pres,
    input logic        i_out_err
);
    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // an error beat carries zeroed results
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_err) |-> (i_out_temp == '0 && i_out_pres == '0))
        else $error("error beat with nonzero results");

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_temp) && $stable(i_out_pres) && $stable(i_out_err)))
        else $error("stalled result changed");

    // a stalled result stalls the sample side
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("sample accepted while output stalled");
endmodule

bind baro_pressure_temp_compensation bpc_chk u_bpc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_temp  (o_res.temperature_tenths),
    .i_out_pres  (o_res.pressure_pa),
    .i_out_err   (o_res.math_error)
);
